>>> rtl/projected_vector_angle_defines.svh
// assertion macros for the projected vector angle checker
// depends on a clk and rst signal in the scope of each use
`ifndef PROJECTED_VECTOR_ANGLE_DEFINES_SVH
`define PROJECTED_VECTOR_ANGLE_DEFINES_SVH

// condition implies expression in the same cycle
`define PVA_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("pva check failed");

// condition implies expression in the next cycle
`define PVA_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("pva check failed");

`endif

>>> rtl/pva_pkg.sv
// shared constants, types and the arctangent table for the projected vector angle
// no dependencies
`default_nettype none

package pva_pkg;

  localparam int DIM                = 3;
  localparam int COMPONENT_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF     = 16;
  localparam int Q_W                = 16;  // internal component, 14 fraction bits
  localparam int P_W                = 20;  // projected component
  localparam int C_W                = 42;  // dot and cross products
  localparam int T_W                = 58;  // triple product
  localparam int MAG_W              = 30;  // normalized magnitudes
  localparam int SS_W               = 63;  // square root operand and partial root
  localparam int SQRT_STEPS         = 31;
  localparam int CORDIC_STEPS       = 28;
  localparam int X_W                = 34;
  localparam int Z_W                = 33;
  localparam int TURN_FRAC          = 30;  // angle fraction bits of one turn

  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    mag_t md;
    logic negdot;
    logic tneg;
    logic degen;
  } side_t;

  typedef struct packed {
    logic tneg;
    logic degen;
  } flags_t;

  // atan(2^-i) in units of 2^-30 turn
  function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      0:  r = Z_W'(134217728);
      1:  r = Z_W'(79233351);
      2:  r = Z_W'(41864727);
      3:  r = Z_W'(21251189);
      4:  r = Z_W'(10666833);
      5:  r = Z_W'(5338616);
      6:  r = Z_W'(2669960);
      7:  r = Z_W'(1335061);
      8:  r = Z_W'(667541);
      9:  r = Z_W'(333772);
      10: r = Z_W'(166886);
      11: r = Z_W'(83443);
      12: r = Z_W'(41722);
      13: r = Z_W'(20861);
      14: r = Z_W'(10430);
      15: r = Z_W'(5215);
      16: r = Z_W'(2608);
      17: r = Z_W'(1304);
      18: r = Z_W'(652);
      19: r = Z_W'(326);
      20: r = Z_W'(163);
      21: r = Z_W'(81);
      22: r = Z_W'(41);
      23: r = Z_W'(20);
      24: r = Z_W'(10);
      25: r = Z_W'(5);
      26: r = Z_W'(3);
      27: r = Z_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/projected_vector_angle.sv
// Projected vector angle, top level.
// Takes two 3D vectors and a plane normal per transaction on the item channel
// (item_valid / item_stall) and returns the signed angle from the first to the
// second projection as a fraction of a full turn, plus a degenerate flag, on
// the result channel (result_valid / result_stall).
// From an accepted item to its result the data passes 11 projection and
// product stages, a chain of 31 square root cells, one CORDIC setup stage,
// a chain of 28 CORDIC cells and the output register.
// Throughput is one transaction per cycle unless the output is held; every
// stage is a register that moves forward on the same enable.
// When the result is held by result_stall the whole chain holds and
// item_stall is raised; otherwise a new item is taken every cycle.
// Synchronous reset clears all valid bits, so no result is shown afterwards
// until new items have passed the chain.
// Depends on pva_pkg, pva_front, pva_sqrt_cell and pva_cordic_cell.
`default_nettype none

module projected_vector_angle import pva_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic signed [COMPONENT_BITS-1:0] first_x,
  input  logic signed [COMPONENT_BITS-1:0] first_y,
  input  logic signed [COMPONENT_BITS-1:0] first_z,
  input  logic signed [COMPONENT_BITS-1:0] second_x,
  input  logic signed [COMPONENT_BITS-1:0] second_y,
  input  logic signed [COMPONENT_BITS-1:0] second_z,
  input  logic signed [COMPONENT_BITS-1:0] normal_x,
  input  logic signed [COMPONENT_BITS-1:0] normal_y,
  input  logic signed [COMPONENT_BITS-1:0] normal_z,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic        [ANGLE_BITS-1:0]     angle,
  output logic                             degenerate
);

  localparam int SHR = TURN_FRAC - ANGLE_BITS;
  localparam logic [TURN_FRAC:0] HALF    = (TURN_FRAC+1)'(1) << (SHR - 1);
  localparam logic [TURN_FRAC:0] TURN    = (TURN_FRAC+1)'(1) << TURN_FRAC;
  localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(1) <<< (TURN_FRAC - 1);
  localparam logic signed [Z_W-1:0] QUARTER   = Z_W'(1) <<< (TURN_FRAC - 2);

  logic en;

  // whole chain advances unless a finished result is held
  assign en         = !result_valid || !result_stall;
  assign item_stall = !en;

  logic signed [COMPONENT_BITS-1:0] a_raw [DIM];
  logic signed [COMPONENT_BITS-1:0] b_raw [DIM];
  logic signed [COMPONENT_BITS-1:0] n_raw [DIM];

  assign a_raw = '{first_x, first_y, first_z};
  assign b_raw = '{second_x, second_y, second_z};
  assign n_raw = '{normal_x, normal_y, normal_z};

  logic            front_valid;
  logic [SS_W-1:0] front_ss;
  side_t           front_side;

  pva_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (item_valid && !item_stall),
    .a_raw    (a_raw),
    .b_raw    (b_raw),
    .n_raw    (n_raw),
    .out_valid(front_valid),
    .ss       (front_ss),
    .side     (front_side)
  );

  // square root chain, one result bit per cell
  logic            sq_v    [SQRT_STEPS+1];
  logic [SS_W-1:0] sq_rem  [SQRT_STEPS+1];
  logic [SS_W-1:0] sq_root [SQRT_STEPS+1];
  side_t           sq_side [SQRT_STEPS+1];

  assign sq_v[0]    = front_valid;
  assign sq_rem[0]  = front_ss;
  assign sq_root[0] = '0;
  assign sq_side[0] = front_side;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    pva_sqrt_cell #(.K(SQRT_STEPS - 1 - j)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (sq_v[j]),
      .in_rem   (sq_rem[j]),
      .in_root  (sq_root[j]),
      .in_side  (sq_side[j]),
      .out_valid(sq_v[j+1]),
      .out_rem  (sq_rem[j+1]),
      .out_root (sq_root[j+1]),
      .out_side (sq_side[j+1])
    );
  end

  // cordic setup: pick the start quadrant
  logic                  cd_v     [CORDIC_STEPS+1];
  logic signed [X_W-1:0] cd_x     [CORDIC_STEPS+1];
  logic signed [X_W-1:0] cd_y     [CORDIC_STEPS+1];
  logic signed [Z_W-1:0] cd_z     [CORDIC_STEPS+1];
  flags_t                cd_flags [CORDIC_STEPS+1];

  logic signed [X_W-1:0] root_s, md_s;
  side_t                 sd;

  assign sd     = sq_side[SQRT_STEPS];
  assign root_s = X_W'(sq_root[SQRT_STEPS][MAG_W:0]);
  assign md_s   = X_W'(sd.md);

  always_ff @(posedge clk) begin
    if (rst) begin
      cd_v[0] <= 1'b0;
    end else if (en) begin
      cd_v[0] <= sq_v[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sd.negdot) begin
        cd_x[0] <= root_s;
        cd_y[0] <= md_s;
        cd_z[0] <= QUARTER;
      end else begin
        cd_x[0] <= md_s;
        cd_y[0] <= root_s;
        cd_z[0] <= '0;
      end
      cd_flags[0] <= '{tneg: sd.tneg, degen: sd.degen};
    end
  end

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    pva_cordic_cell #(.K(j)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (cd_v[j]),
      .in_x     (cd_x[j]),
      .in_y     (cd_y[j]),
      .in_z     (cd_z[j]),
      .in_flags (cd_flags[j]),
      .out_valid(cd_v[j+1]),
      .out_x    (cd_x[j+1]),
      .out_y    (cd_y[j+1]),
      .out_z    (cd_z[j+1]),
      .out_flags(cd_flags[j+1])
    );
  end

  // clamp, mirror and round to the output width
  logic signed [Z_W-1:0] zf;
  flags_t                ff;
  logic [TURN_FRAC:0]    zc, zm, zr;

  assign zf = cd_z[CORDIC_STEPS];
  assign ff = cd_flags[CORDIC_STEPS];

  always_comb begin
    if (zf < 0) begin
      zc = '0;
    end else if (zf > HALF_TURN) begin
      zc = (TURN_FRAC+1)'(HALF_TURN);
    end else begin
      zc = (TURN_FRAC+1)'(zf);
    end
    zm = ff.tneg ? TURN - zc : zc;
    zr = (zm + HALF) >> SHR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= cd_v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle      <= ff.degen ? '0 : ANGLE_BITS'(zr);
      degenerate <= ff.degen;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pva_front.sv
// projection, dot, cross and triple products, magnitude normalization and sum of squares
// depends on pva_pkg
`default_nettype none

module pva_front import pva_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [COMPONENT_BITS-1:0] a_raw [DIM],
  input  logic signed [COMPONENT_BITS-1:0] b_raw [DIM],
  input  logic signed [COMPONENT_BITS-1:0] n_raw [DIM],
  output logic                             out_valid,
  output logic        [SS_W-1:0]           ss,
  output side_t                            side
);

  localparam int STAGES = 11;
  localparam int PR_W   = 2 * Q_W;
  localparam int S_W    = PR_W + 2;
  localparam int SN_W   = S_W + Q_W;
  localparam int M_W    = 2 * P_W;
  localparam int D_W    = C_W - 1;
  localparam logic signed [SN_W:0] RND = (SN_W+1)'(1) <<< 27;

  logic [STAGES-1:0] vld;

  logic signed [Q_W-1:0] a_q [DIM];
  logic signed [Q_W-1:0] b_q [DIM];
  logic signed [Q_W-1:0] n_q [DIM];

  // bring components to the internal 14 fraction bit format
  for (genvar i = 0; i < DIM; i++) begin : g_load
    if (COMPONENT_BITS >= Q_W) begin : g_narrow
      assign a_q[i] = Q_W'(a_raw[i] >>> (COMPONENT_BITS - Q_W));
      assign b_q[i] = Q_W'(b_raw[i] >>> (COMPONENT_BITS - Q_W));
      assign n_q[i] = Q_W'(n_raw[i] >>> (COMPONENT_BITS - Q_W));
    end else begin : g_widen
      assign a_q[i] = Q_W'(a_raw[i]) <<< (Q_W - COMPONENT_BITS);
      assign b_q[i] = Q_W'(b_raw[i]) <<< (Q_W - COMPONENT_BITS);
      assign n_q[i] = Q_W'(n_raw[i]) <<< (Q_W - COMPONENT_BITS);
    end
  end

  // valid shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end
  assign out_valid = vld[STAGES-1];

  // stage 1: v times n
  logic signed [Q_W-1:0]  a1 [DIM], b1 [DIM], n1 [DIM];
  logic signed [PR_W-1:0] an1 [DIM], bn1 [DIM];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIM; i++) begin
        a1[i]  <= a_q[i];
        b1[i]  <= b_q[i];
        n1[i]  <= n_q[i];
        an1[i] <= a_q[i] * n_q[i];
        bn1[i] <= b_q[i] * n_q[i];
      end
    end
  end

  // stage 2: dot with the normal
  logic signed [Q_W-1:0] a2 [DIM], b2 [DIM], n2 [DIM];
  logic signed [S_W-1:0] sa2, sb2;
  always_ff @(posedge clk) begin
    if (en) begin
      a2  <= a1;
      b2  <= b1;
      n2  <= n1;
      sa2 <= S_W'(an1[0]) + S_W'(an1[1]) + S_W'(an1[2]);
      sb2 <= S_W'(bn1[0]) + S_W'(bn1[1]) + S_W'(bn1[2]);
    end
  end

  // stage 3: normal component
  logic signed [Q_W-1:0]  a3 [DIM], b3 [DIM], n3 [DIM];
  logic signed [SN_W-1:0] san3 [DIM], sbn3 [DIM];
  always_ff @(posedge clk) begin
    if (en) begin
      a3 <= a2;
      b3 <= b2;
      n3 <= n2;
      for (int i = 0; i < DIM; i++) begin
        san3[i] <= sa2 * n2[i];
        sbn3[i] <= sb2 * n2[i];
      end
    end
  end

  // stage 4: subtract the rounded normal component
  logic signed [SN_W:0]  adj_a [DIM], adj_b [DIM];
  logic signed [P_W-1:0] pa4 [DIM], pb4 [DIM];
  logic signed [Q_W-1:0] n4 [DIM];
  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      adj_a[i] = (RND - (SN_W+1)'(san3[i])) >>> 28;
      adj_b[i] = (RND - (SN_W+1)'(sbn3[i])) >>> 28;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      n4 <= n3;
      for (int i = 0; i < DIM; i++) begin
        pa4[i] <= P_W'(a3[i]) + P_W'(adj_a[i]);
        pb4[i] <= P_W'(b3[i]) + P_W'(adj_b[i]);
      end
    end
  end

  // stage 5: pairwise products and zero test
  logic signed [M_W-1:0] pq5 [DIM];
  logic signed [M_W-1:0] m5 [6];
  logic signed [Q_W-1:0] n5 [DIM];
  logic                  degen5;
  always_ff @(posedge clk) begin
    if (en) begin
      n5     <= n4;
      degen5 <= ((pa4[0] == '0) && (pa4[1] == '0) && (pa4[2] == '0)) ||
                ((pb4[0] == '0) && (pb4[1] == '0) && (pb4[2] == '0));
      for (int i = 0; i < DIM; i++) begin
        pq5[i] <= pa4[i] * pb4[i];
      end
      m5[0] <= pa4[1] * pb4[2];
      m5[1] <= pa4[2] * pb4[1];
      m5[2] <= pa4[2] * pb4[0];
      m5[3] <= pa4[0] * pb4[2];
      m5[4] <= pa4[0] * pb4[1];
      m5[5] <= pa4[1] * pb4[0];
    end
  end

  // stage 6: dot and cross product
  logic signed [C_W-1:0] dot6;
  logic signed [C_W-1:0] c6 [DIM];
  logic signed [Q_W-1:0] n6 [DIM];
  logic                  degen6;
  always_ff @(posedge clk) begin
    if (en) begin
      n6     <= n5;
      degen6 <= degen5;
      dot6   <= C_W'(pq5[0]) + C_W'(pq5[1]) + C_W'(pq5[2]);
      c6[0]  <= C_W'(m5[0]) - C_W'(m5[1]);
      c6[1]  <= C_W'(m5[2]) - C_W'(m5[3]);
      c6[2]  <= C_W'(m5[4]) - C_W'(m5[5]);
    end
  end

  // stage 7: triple product terms and magnitudes
  logic signed [T_W-1:0] cn7 [DIM];
  logic        [D_W-1:0] md7;
  logic        [D_W-1:0] mc7 [DIM];
  logic                  negdot7, degen7;
  always_ff @(posedge clk) begin
    if (en) begin
      negdot7 <= dot6 < 0;
      degen7  <= degen6;
      md7     <= D_W'((dot6 < 0) ? -dot6 : dot6);
      for (int i = 0; i < DIM; i++) begin
        cn7[i] <= c6[i] * n6[i];
        mc7[i] <= D_W'((c6[i] < 0) ? -c6[i] : c6[i]);
      end
    end
  end

  // stage 8: triple sign and normalizing shift
  logic [D_W-1:0] big;
  logic [3:0]     sh_c;
  logic [3:0]     sh8;
  logic [D_W-1:0] md8;
  logic [D_W-1:0] mc8 [DIM];
  logic           negdot8, degen8, tneg8;
  logic signed [T_W-1:0] triple;
  always_comb begin
    big    = md7 | mc7[0] | mc7[1] | mc7[2];
    triple = cn7[0] + cn7[1] + cn7[2];
    sh_c   = '0;
    for (int b = MAG_W; b < D_W; b++) begin
      if (big[b]) sh_c = 4'(b - MAG_W + 1);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sh8     <= sh_c;
      md8     <= md7;
      mc8     <= mc7;
      negdot8 <= negdot7;
      degen8  <= degen7;
      tneg8   <= triple < 0;
    end
  end

  // stage 9: apply the shift
  mag_t md9;
  mag_t mc9 [DIM];
  logic negdot9, degen9, tneg9;
  always_ff @(posedge clk) begin
    if (en) begin
      md9     <= MAG_W'(md8 >> sh8);
      for (int i = 0; i < DIM; i++) begin
        mc9[i] <= MAG_W'(mc8[i] >> sh8);
      end
      negdot9 <= negdot8;
      degen9  <= degen8;
      tneg9   <= tneg8;
    end
  end

  // stage 10: squares of the cross magnitudes
  logic [2*MAG_W-1:0] sq10 [DIM];
  side_t              side10;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIM; i++) begin
        sq10[i] <= mc9[i] * mc9[i];
      end
      side10 <= '{md: md9, negdot: negdot9, tneg: tneg9, degen: degen9};
    end
  end

  // stage 11: sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      ss   <= SS_W'(sq10[0]) + SS_W'(sq10[1]) + SS_W'(sq10[2]);
      side <= side10;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pva_sqrt_cell.sv
// one digit step of the integer square root chain
// depends on pva_pkg
`default_nettype none

module pva_sqrt_cell import pva_pkg::*; #(
  parameter int K = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [SS_W-1:0] in_rem,
  input  logic [SS_W-1:0] in_root,
  input  side_t           in_side,
  output logic            out_valid,
  output logic [SS_W-1:0] out_rem,
  output logic [SS_W-1:0] out_root,
  output side_t           out_side
);

  localparam logic [SS_W-1:0] BIT = SS_W'(1) << (2 * K);

  logic [SS_W-1:0] trial;
  logic            take;

  // trial subtraction for this digit
  always_comb begin
    trial = in_root + BIT;
    take  = in_rem >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= take ? in_rem - trial : in_rem;
      out_root <= take ? (in_root >> 1) + BIT : in_root >> 1;
      out_side <= in_side;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pva_cordic_cell.sv
// one vectoring rotation of the arctangent chain
// depends on pva_pkg
`default_nettype none

module pva_cordic_cell import pva_pkg::*; #(
  parameter int K = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [X_W-1:0] in_x,
  input  logic signed [X_W-1:0] in_y,
  input  logic signed [Z_W-1:0] in_z,
  input  flags_t                in_flags,
  output logic                  out_valid,
  output logic signed [X_W-1:0] out_x,
  output logic signed [X_W-1:0] out_y,
  output logic signed [Z_W-1:0] out_z,
  output flags_t                out_flags
);

  localparam logic signed [Z_W-1:0] ANG = atan_entry(K);

  logic signed [X_W-1:0] xs, ys;

  assign xs = in_x >>> K;
  assign ys = in_y >>> K;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // rotate toward the x axis
  always_ff @(posedge clk) begin
    if (en) begin
      if (in_y >= 0) begin
        out_x <= in_x + ys;
        out_y <= in_y - xs;
        out_z <= in_z + ANG;
      end else begin
        out_x <= in_x - ys;
        out_y <= in_y + xs;
        out_z <= in_z - ANG;
      end
      out_flags <= in_flags;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pva_checker.sv
// port level checks for the projected vector angle, bound to the top level
// depends on pva_pkg, projected_vector_angle_defines.svh and projected_vector_angle
`default_nettype none
`include "projected_vector_angle_defines.svh"

module pva_checker import pva_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  item_stall,
  input wire logic                  result_valid,
  input wire logic                  result_stall,
  input wire logic [ANGLE_BITS-1:0] angle,
  input wire logic                  degenerate
);

  // a held result keeps its payload
  `PVA_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(angle) && $stable(degenerate))

  // a degenerate transaction always reports a zero angle
  `PVA_ASSERT_NOW(a_degen_zero, result_valid && degenerate, angle == '0)

  // the input side only stalls while a result is held
  `PVA_ASSERT_NOW(a_stall_cause, item_stall, result_valid && result_stall)

endmodule

bind projected_vector_angle pva_checker #(.ANGLE_BITS(ANGLE_BITS)) u_pva_checker (.*);

`default_nettype wire
